/* hdl/dcmd_pkg.sv */
// shared types and constants of the dc median dpcm block
package dcmd_pkg;

  // prediction of the first block of a picture
  localparam int FirstPred = 1024;

  // configuration register indexes
  localparam logic [1:0] RegBypass    = 2'd0;
  localparam logic [1:0] RegDirection = 2'd1;
  localparam logic [1:0] RegRowBlocks = 2'd2;

  localparam int CfgIdxBits  = 2;
  localparam int CfgDataBits = 9;

  // position of one block within the picture, worked out at accept
  typedef struct packed {
    logic first;      // first block of a picture
    logic first_row;  // block lies in the top row
    logic col_zero;   // block starts a row
    logic row_end;    // block ends a row
  } dcmd_pos_t;

endpackage

/* hdl/dcmd_line_store.sv */
// dual copy line store of reconstructed dc values, one read port per copy
module dcmd_line_store #(
  parameter int Depth = 256,
  parameter int AddrBits = 8,
  parameter int DataBits = 12
) (
  input  logic                       clk_i,
  input  logic                       rd_en_i,
  input  logic [AddrBits-1:0]        rd_addr_a_i,
  input  logic [AddrBits-1:0]        rd_addr_b_i,
  input  logic                       wr_en_i,
  input  logic [AddrBits-1:0]        wr_addr_i,
  input  logic signed [DataBits-1:0] wr_data_i,
  output logic signed [DataBits-1:0] rd_data_a_o,
  output logic signed [DataBits-1:0] rd_data_b_o
);

  logic signed [DataBits-1:0] mem_a [Depth];
  logic signed [DataBits-1:0] mem_b [Depth];

  // both copies take every write so each can serve its own read address
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_a[wr_addr_i] <= wr_data_i;
      mem_b[wr_addr_i] <= wr_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_a_o <= mem_a[rd_addr_a_i];
      rd_data_b_o <= mem_b[rd_addr_b_i];
    end
  end

endmodule

/* hdl/dcmd_predict.sv */
// median prediction, residual and reconstruction for one block
module dcmd_predict
  import dcmd_pkg::*;
#(
  parameter int DcBits = 12
) (
  input  dcmd_pos_t                 pos_i,
  input  logic                      bypass_i,
  input  logic                      direction_i,
  input  logic signed [DcBits:0]    sample_i,
  input  logic signed [DcBits-1:0]  up_i,
  input  logic signed [DcBits-1:0]  upr_i,
  input  logic signed [DcBits-1:0]  left_i,
  input  logic signed [DcBits-1:0]  disp_i,
  output logic signed [DcBits:0]    res_o,
  output logic signed [DcBits-1:0]  pred_o,
  output logic signed [DcBits-1:0]  dc_o
);

  localparam logic signed [DcBits-1:0] DcMax = {1'b0, {(DcBits-1){1'b1}}};
  localparam logic signed [DcBits-1:0] DcMin = {1'b1, {(DcBits-1){1'b0}}};

  function automatic logic signed [DcBits-1:0] sat_dc(input logic signed [DcBits+1:0] v);
    logic signed [DcBits-1:0] r;
    if (v > $signed({{2{DcMax[DcBits-1]}}, DcMax})) r = DcMax;
    else if (v < $signed({{2{DcMin[DcBits-1]}}, DcMin})) r = DcMin;
    else r = v[DcBits-1:0];
    return r;
  endfunction

  logic signed [DcBits-1:0] lf, ur, lo, hi, mid, med, pred;
  logic signed [DcBits+1:0] x_ext, sum;
  logic signed [DcBits-1:0] dc;

  always_comb begin
    lf = pos_i.col_zero ? up_i : left_i;
    if (pos_i.row_end) ur = pos_i.col_zero ? up_i : disp_i;
    else ur = upr_i;

    // median of three
    lo  = (lf < up_i) ? lf : up_i;
    hi  = (lf < up_i) ? up_i : lf;
    mid = (hi < ur) ? hi : ur;
    med = (lo > mid) ? lo : mid;

    if (pos_i.first) pred = DcBits'(FirstPred);
    else if (pos_i.first_row) pred = left_i;
    else pred = med;

    x_ext = {sample_i[DcBits], sample_i};
    sum   = x_ext + {{2{pred[DcBits-1]}}, pred};
    dc    = direction_i ? sat_dc(sum) : sat_dc(x_ext);

    if (bypass_i) begin
      res_o  = sample_i;
      pred_o = '0;
    end else if (direction_i) begin
      res_o  = {dc[DcBits-1], dc};
      pred_o = pred;
    end else begin
      res_o  = {dc[DcBits-1], dc} - {pred[DcBits-1], pred};
      pred_o = pred;
    end
    dc_o = dc;
  end

endmodule

/* hdl/dc_median_dpcm.sv */
// top level of the dc median dpcm block
//
//  channel   direction  handshake               payload
//  -------   ---------  ----------------------  ---------------------------------
//  input     in         in_valid_i/in_stall_o   frame_start_i, sample_in_i
//  output    out        out_valid_o/out_stall_i sample_out_o, prediction_o
//  config    in         cfg_we_i                cfg_idx_i, cfg_data_i
//
// one block per cycle sustained while the output does not stall; a result passes
// the line store read and predict stage registers, then the output register
// the line store is two copies of one row of dcs, so up and upper-right are
// read in the same cycle; no clearing pass, the top row does not use what it reads
// a store write at the edge that issues the next block's reads is forwarded
// reset clears position, left and displaced-up values and all valid flags
// a stall on the output holds the predict stage, which stalls the input
module dc_median_dpcm
  import dcmd_pkg::*;
#(
  parameter int MAX_ROW_BLOCKS = 256,
  parameter int DC_BITS = 12
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  // configuration
  input  logic                        cfg_we_i,
  input  logic [CfgIdxBits-1:0]       cfg_idx_i,
  input  logic [CfgDataBits-1:0]      cfg_data_i,
  // input requests
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  logic                        frame_start_i,
  input  logic signed [DC_BITS:0]     sample_in_i,
  // output requests
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output logic signed [DC_BITS:0]     sample_out_o,
  output logic signed [DC_BITS-1:0]   prediction_o
);

  localparam int AW = (MAX_ROW_BLOCKS > 1) ? $clog2(MAX_ROW_BLOCKS) : 1;
  // wide enough for the row width itself and for the config value
  localparam int WW = (AW + 1 > CfgDataBits) ? AW + 1 : CfgDataBits;
  localparam logic [WW-1:0] WidthMin = WW'(2);
  localparam logic [WW-1:0] WidthMax = WW'(MAX_ROW_BLOCKS);

  // configuration registers
  logic                   bypass_q, direction_q;
  logic [CfgDataBits-1:0] row_blocks_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bypass_q     <= 1'b0;
      direction_q  <= 1'b0;
      row_blocks_q <= CfgDataBits'(64);
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        RegBypass:    bypass_q     <= cfg_data_i[0];
        RegDirection: direction_q  <= cfg_data_i[0];
        RegRowBlocks: row_blocks_q <= cfg_data_i;
        default:      ;
      endcase
    end
  end

  // effective row width, clamped to the supported range
  logic [WW-1:0] width;
  always_comb begin
    width = WW'(row_blocks_q);
    if (width < WidthMin) width = WidthMin;
    if (width > WidthMax) width = WidthMax;
  end

  // position state, advanced at every accepted request
  logic [AW-1:0] col_q, col_d;
  logic          first_row_q, first_row_d;
  logic          at_start_q;

  logic          in_accept;
  logic [AW-1:0] col_base, col_cur;
  logic          fr_base, fs_base, fr_cur;
  logic [WW-1:0] col_next;
  dcmd_pos_t     pos_cur;

  always_comb begin
    col_base = frame_start_i ? '0 : col_q;
    fr_base  = frame_start_i | first_row_q;
    fs_base  = frame_start_i | at_start_q;
    // a column past the width (after a narrower width was set) opens a new row
    if (WW'(col_base) >= width) begin
      col_cur = '0;
      fr_cur  = 1'b0;
    end else begin
      col_cur = col_base;
      fr_cur  = fr_base;
    end
    col_next          = WW'(col_cur) + WW'(1);
    pos_cur.first     = fs_base;
    pos_cur.first_row = fr_cur;
    pos_cur.col_zero  = (col_cur == '0);
    pos_cur.row_end   = (col_next >= width);
    if (pos_cur.row_end) begin
      col_d       = '0;
      first_row_d = 1'b0;
    end else begin
      col_d       = col_next[AW-1:0];
      first_row_d = fr_cur;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q       <= '0;
      first_row_q <= 1'b1;
      at_start_q  <= 1'b1;
    end else if (in_accept) begin
      col_q       <= col_d;
      first_row_q <= first_row_d;
      at_start_q  <= 1'b0;
    end
  end

  // predict stage: holds the block whose store reads are in flight
  logic                     s2_valid_q;
  dcmd_pos_t                s2_pos_q;
  logic [AW-1:0]            s2_col_q;
  logic signed [DC_BITS:0]  s2_sample_q;
  logic                     out_valid_q;
  logic                     out_load;

  assign out_load   = s2_valid_q & (~out_valid_q | ~out_stall_i);
  assign in_stall_o = s2_valid_q & ~out_load;
  assign in_accept  = in_valid_i & ~in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_valid_q <= 1'b0;
    end else if (in_accept) begin
      s2_valid_q <= 1'b1;
    end else if (out_load) begin
      s2_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      s2_pos_q    <= pos_cur;
      s2_col_q    <= col_cur;
      s2_sample_q <= sample_in_i;
    end
  end

  // line store: up at the block's column, upper-right one further
  logic signed [DC_BITS-1:0] up_rd, upr_rd;
  logic signed [DC_BITS-1:0] dc;
  logic                      store_we;

  assign store_we = out_load & ~bypass_q;

  dcmd_line_store #(
    .Depth    (MAX_ROW_BLOCKS),
    .AddrBits (AW),
    .DataBits (DC_BITS)
  ) u_store (
    .clk_i       (clk_i),
    .rd_en_i     (in_accept),
    .rd_addr_a_i (col_cur),
    .rd_addr_b_i (col_next[AW-1:0]),
    .wr_en_i     (store_we),
    .wr_addr_i   (s2_col_q),
    .wr_data_i   (dc),
    .rd_data_a_o (up_rd),
    .rd_data_b_o (upr_rd)
  );

  // the store write of the block leaving the predict stage lands at the same edge
  // as the reads of the next block; the read port would return the old entry
  // (narrow rows: upper-right of a row start is the entry just written)
  logic                      fwd_up_q, fwd_upr_q;
  logic signed [DC_BITS-1:0] fwd_dc_q;
  logic signed [DC_BITS-1:0] up_val, upr_val;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fwd_up_q  <= 1'b0;
      fwd_upr_q <= 1'b0;
    end else if (in_accept) begin
      fwd_up_q  <= store_we & (s2_col_q == col_cur);
      fwd_upr_q <= store_we & (s2_col_q == col_next[AW-1:0]);
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      fwd_dc_q <= dc;
    end
  end

  assign up_val  = fwd_up_q ? fwd_dc_q : up_rd;
  assign upr_val = fwd_upr_q ? fwd_dc_q : upr_rd;

  // last stored dc and the store value it displaced (upper-left of the next block)
  logic signed [DC_BITS-1:0] left_q, disp_q;
  logic signed [DC_BITS:0]   res;
  logic signed [DC_BITS-1:0] pred;

  dcmd_predict #(
    .DcBits (DC_BITS)
  ) u_predict (
    .pos_i       (s2_pos_q),
    .bypass_i    (bypass_q),
    .direction_i (direction_q),
    .sample_i    (s2_sample_q),
    .up_i        (up_val),
    .upr_i       (upr_val),
    .left_i      (left_q),
    .disp_i      (disp_q),
    .res_o       (res),
    .pred_o      (pred),
    .dc_o        (dc)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      left_q <= '0;
      disp_q <= '0;
    end else if (store_we) begin
      left_q <= dc;
      disp_q <= up_val;
    end
  end

  // output register
  logic signed [DC_BITS:0]   sample_out_q;
  logic signed [DC_BITS-1:0] prediction_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      sample_out_q <= res;
      prediction_q <= pred;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign sample_out_o = sample_out_q;
  assign prediction_o = prediction_q;

endmodule

/* tb/sv/tb_top.sv */
// self-checking testbench of the dc median dpcm block with a built-in predictor
`timescale 1ns / 1ps

module tb_top;
  import dcmd_pkg::*;

  localparam int DcBits      = 12;
  localparam int RowMax      = 256;
  localparam int DcHi        = 2047;
  localparam int DcLo        = -2048;
  localparam int QuietLimit  = 1000;  // cycles with no handshake before giving up
  localparam int DrainCycles = 4;     // cycles waited after draining for any stray result

  // one expected output request
  typedef struct {
    logic signed [DcBits:0]   sample;
    logic signed [DcBits-1:0] pred;
  } dc_result_t;

  logic                    clk_i         = 1'b0;
  logic                    rst_ni        = 1'b0;
  logic                    cfg_we_i      = 1'b0;
  logic [CfgIdxBits-1:0]   cfg_idx_i     = RegBypass;
  logic [CfgDataBits-1:0]  cfg_data_i    = '0;
  logic                    in_valid_i    = 1'b0;
  logic                    in_stall_o;
  logic                    frame_start_i = 1'b0;
  logic signed [DcBits:0]  sample_in_i   = '0;
  logic                    out_valid_o;
  logic                    out_stall_i   = 1'b0;
  logic signed [DcBits:0]  sample_out_o;
  logic signed [DcBits-1:0] prediction_o;

  dc_median_dpcm uut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_data_i   (cfg_data_i),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .frame_start_i(frame_start_i),
    .sample_in_i  (sample_in_i),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .sample_out_o (sample_out_o),
    .prediction_o (prediction_o)
  );

  // shadow copy of the configuration, reset values
  bit          bypass_q  = 1'b0;
  bit          decode_q  = 1'b0;
  int unsigned row_cfg_q = 64;

  // shadow copy of the prediction state
  int          dc_row [RowMax];   // reconstructed dcs of the row above
  int          last_dc    = 0;    // left neighbor
  int          upleft_dc  = 0;    // store entry displaced by the last write
  int unsigned col_q      = 0;
  bit          top_row_q  = 1'b1;
  bit          pic_head_q = 1'b1;

  dc_result_t  due_results[$];    // results still owed by the block, oldest first
  int          errors          = 0;
  int          sender_idle_pct = 0;
  int          stall_pct       = 0;
  int          level           = 0;  // slowly drifting dc for smooth pictures

  // 2 ns clock
  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  function automatic int sat_dc(input int v);
    if (v > DcHi) return DcHi;
    if (v < DcLo) return DcLo;
    return v;
  endfunction

  function automatic int median3(input int a, input int b, input int c);
    int lo, hi, mid;
    lo  = (a < b) ? a : b;
    hi  = (a < b) ? b : a;
    mid = (hi < c) ? hi : c;
    return (lo > mid) ? lo : mid;
  endfunction

  // advance the shadow state by one accepted block and return what the block owes
  function automatic dc_result_t predict_block(input bit fs, input logic signed [DcBits:0] smp);
    dc_result_t  r;
    int unsigned w, c;
    int          x, pred, dc, res, up, lf, ur;
    // row width register is clamped to the legal range
    w = row_cfg_q;
    if (w < 2) w = 2;
    if (w > RowMax) w = RowMax;
    x    = smp;
    pred = 0;
    if (fs) begin
      col_q      = 0;
      top_row_q  = 1'b1;
      pic_head_q = 1'b1;
    end
    // width shrank mid picture: wrap into a new row
    if (col_q >= w) begin
      col_q     = 0;
      top_row_q = 1'b0;
    end
    c = col_q;
    if (bypass_q) begin
      res = x;
    end else begin
      if (pic_head_q) begin
        pred = FirstPred;
      end else if (top_row_q) begin
        pred = last_dc;
      end else begin
        up = dc_row[c];
        // row start: up replaces left; row end: upper-left replaces upper-right
        lf = (c == 0) ? up : last_dc;
        if (c + 1 >= w) ur = (c == 0) ? up : upleft_dc;
        else ur = dc_row[c + 1];
        pred = median3(lf, up, ur);
      end
      if (decode_q) begin
        dc  = sat_dc(x + pred);
        res = dc;
      end else begin
        dc  = sat_dc(x);
        res = dc - pred;
      end
      upleft_dc  = dc_row[c];
      dc_row[c]  = dc;
      last_dc    = dc;
    end
    pic_head_q = 1'b0;
    if (c + 1 >= w) begin
      col_q     = 0;
      top_row_q = 1'b0;
    end else begin
      col_q = c + 1;
    end
    r.sample = res[DcBits:0];
    r.pred   = pred[DcBits-1:0];
    return r;
  endfunction

  // random dc or residual: field extremes, full range, or smooth content
  function automatic int pick_sample();
    int r;
    r = $urandom_range(99);
    if (r < 8) return ($urandom_range(1) != 0) ? 4095 : -4096;
    if (r < 14) return ($urandom_range(1) != 0) ? DcHi : DcLo;
    if (r < 34) return int'($urandom_range(8191)) - 4096;
    if (decode_q) return int'($urandom_range(64)) - 32;
    level = sat_dc(level + int'($urandom_range(128)) - 64);
    return level;
  endfunction

  // one register write, taken at the next rising edge
  task automatic write_reg(input logic [CfgIdxBits-1:0] idx, input int unsigned data);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= data[CfgDataBits-1:0];
    @(posedge clk_i);
    case (idx)
      RegBypass:    bypass_q  = data[0];
      RegDirection: decode_q  = data[0];
      RegRowBlocks: row_cfg_q = data[CfgDataBits-1:0];
      default: ;
    endcase
  endtask

  // only called while nothing is in flight
  task automatic configure(input bit bypass, input bit decode, input int unsigned rows);
    write_reg(RegBypass, bypass);
    write_reg(RegDirection, decode);
    write_reg(RegRowBlocks, rows);
    cfg_we_i <= 1'b0;
  endtask

  task automatic set_idling(input int sender, input int receiver);
    sender_idle_pct = sender;
    stall_pct       = receiver;
  endtask

  // present one input request, hold it until taken, then book its result
  task automatic send_block(input bit fs, input int smp);
    while ($urandom_range(99) < sender_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i    <= 1'b1;
    frame_start_i <= fs;
    sample_in_i   <= smp[DcBits:0];
    do @(posedge clk_i); while (in_stall_o !== 1'b0);
    due_results.push_back(predict_block(fs, smp[DcBits:0]));
  endtask

  // stop sending and wait for every owed result
  task automatic drain();
    in_valid_i <= 1'b0;
    while (due_results.size() != 0) @(posedge clk_i);
  endtask

  // first block, first row, median with row start and row end, encode saturation
  task automatic test_encode_prediction();
    configure(1'b0, 1'b0, 3);
    set_idling(0, 0);
    send_block(1'b1, 4095);
    send_block(1'b0, -4096);
    send_block(1'b0, 100);
    send_block(1'b0, -2048);
    send_block(1'b0, 2047);
    send_block(1'b0, 0);
    send_block(1'b0, -1);
    send_block(1'b0, 1);
    send_block(1'b0, -4096);
    // picture restart at the start of a row
    send_block(1'b1, 0);
    drain();
  endtask

  // decode saturates both ways; row width below the minimum acts as two
  task automatic test_decode_saturation();
    configure(1'b0, 1'b1, 1);
    set_idling(28, 28);
    send_block(1'b1, 4095);
    send_block(1'b0, -4096);
    send_block(1'b0, 4095);
    send_block(1'b0, -4096);
    send_block(1'b0, 0);
    send_block(1'b0, -1);
    drain();
  endtask

  // pass through with an oversized row width register
  task automatic test_bypass();
    configure(1'b1, 1'b0, 511);
    set_idling(0, 56);
    send_block(1'b1, -4096);
    send_block(1'b0, 4095);
    send_block(1'b0, 1);
    send_block(1'b1, -1);
    drain();
  endtask

  // row width shrinks mid picture: column already past the new width wraps
  task automatic test_row_shrink();
    configure(1'b0, 1'b0, 3);
    set_idling(56, 0);
    send_block(1'b1, 10);
    send_block(1'b0, 20);
    send_block(1'b0, 30);
    send_block(1'b0, 40);
    send_block(1'b0, 50);
    drain();
    configure(1'b0, 1'b0, 2);
    send_block(1'b0, 60);
    send_block(1'b0, 70);
    send_block(1'b0, -5);
    drain();
  endtask

  // one stretch of random pictures under one setting; always opens a picture so
  // the top row fills the line store before anything reads it
  task automatic random_phase(input bit bypass, input bit decode, input int unsigned rows,
                              input int idle, input int stall, input int items,
                              input int restart_pct);
    configure(bypass, decode, rows);
    set_idling(idle, stall);
    for (int i = 0; i < items; i++) begin
      send_block((i == 0) || ($urandom_range(99) < restart_pct), pick_sample());
    end
    drain();
  endtask

  task automatic test_random_pictures();
    random_phase(1'b0, 1'b0, 5, 0, 0, 20, 3);
    random_phase(1'b0, 1'b1, 2, 56, 0, 20, 3);
    // widest row, long enough to reach the second row
    random_phase(1'b0, 1'b0, RowMax, 28, 28, RowMax + 6, 0);
    random_phase(1'b1, 1'b0, 7, 0, 56, 10, 5);
    random_phase(1'b0, 1'b1, 16, 28, 28, 15, 2);
    random_phase(1'b0, 1'b0, $urandom_range(12, 2), 0, 56, 15, 3);
    random_phase(1'b1, 1'b1, $urandom_range(12, 2), 56, 0, 10, 5);
    random_phase(1'b0, 1'b1, $urandom_range(20, 2), 0, 0, 20, 3);
  endtask

  // receiver back-pressure
  always @(posedge clk_i) begin
    out_stall_i <= ($urandom_range(99) < stall_pct);
  end

  // compare each output request with the oldest booked result
  always @(posedge clk_i) begin
    dc_result_t want;
    if (rst_ni && out_valid_o === 1'b1 && out_stall_i == 1'b0) begin
      if (due_results.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual sample_out %0d prediction %0d",
                 $time, sample_out_o, prediction_o);
        errors++;
      end else begin
        want = due_results.pop_front();
        if (sample_out_o !== want.sample) begin
          $display("%0t: sample_out expected %0d actual %0d", $time, want.sample, sample_out_o);
          errors++;
        end
        if (prediction_o !== want.pred) begin
          $display("%0t: prediction expected %0d actual %0d", $time, want.pred, prediction_o);
          errors++;
        end
      end
    end
  end

  // watchdog: too long without any handshake or register write
  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < QuietLimit) begin
      @(posedge clk_i);
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) || cfg_we_i) quiet = 0;
      else quiet++;
    end
    $display("Some tests failed");
    $finish;
  end

  initial begin
    // reset asserted from the start, released once
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    test_encode_prediction();
    test_decode_saturation();
    test_bypass();
    test_row_shrink();
    test_random_pictures();
    drain();
    // catch any stray result after the last one owed
    repeat (DrainCycles) @(posedge clk_i);
    if (errors == 0) $display("All tests passed");
    else $display("Some tests failed");
    $finish;
  end

endmodule
